[sv/ccu_pkg.sv]
// ccu_pkg: widths, mode and status codes and the divider command types
// shared by the combinatorial count unit. No dependencies.
package ccu_pkg;

    localparam int MAX_N       = 100;
    localparam int MODE_W      = 3;
    localparam int N_W         = 7;
    localparam int F_W         = 8;
    localparam int VAL_W       = 64;
    localparam int STAT_W      = 2;
    localparam int PROD_W      = VAL_W + F_W;
    localparam int DIV_DIGIT_W = 8;
    localparam int DIV_CYCLES  = PROD_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [MODE_W-1:0] MODE_POWER    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FALLING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MULTISET = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHOOSE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FACT     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [N_W-1:0]    divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

[sv/ccu_if.sv]
// ccu_req_if and ccu_rsp_if: valid/ready channels for request and result words.
// Depends on ccu_pkg.
interface ccu_req_if;
    import ccu_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] req_type;
    logic [N_W-1:0]    set_size;
    logic [N_W-1:0]    subset_size;

    modport source (output valid, req_type, set_size, subset_size, input ready);
    modport sink   (input valid, req_type, set_size, subset_size, output ready);
endinterface

interface ccu_rsp_if;
    import ccu_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  count_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, count_value, status, input ready);
    modport sink   (input valid, count_value, status, output ready);
endinterface

[sv/ccu_divider.sv]
// ccu_divider: iterative restoring divider, one 8-bit quotient digit per cycle.
// Divides a 72-bit product by a 7-bit nonzero divisor. Depends on ccu_pkg.
module ccu_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  ccu_pkg::div_cmd_t cmd,
    output ccu_pkg::div_rsp_t rsp
);
    import ccu_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [PROD_W-1:0]    shift_reg, shift_next;
    logic [N_W-1:0]       rem_reg,   rem_next;
    logic [N_W-1:0]       dsr_reg,   dsr_next;

    logic [N_W-1:0]         rem_step;
    logic [N_W:0]           trial;
    logic [DIV_DIGIT_W-1:0] digit;
    logic [DIV_DIGIT_W-1:0] qdigit;

    // one quotient digit from the top byte of the shift register
    always_comb
    begin
        rem_step = rem_reg;
        digit    = shift_reg[PROD_W-1 -: DIV_DIGIT_W];
        qdigit   = '0;
        trial    = '0;
        for (int j = DIV_DIGIT_W - 1; j >= 0; j--)
        begin
            trial = {rem_step, digit[j]};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_step  = N_W'(trial - {1'b0, dsr_reg});
                qdigit[j] = 1'b1;
            end
            else
            begin
                rem_step = trial[N_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = cmd.dividend;
            rem_next   = '0;
            dsr_next   = cmd.divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[PROD_W-DIV_DIGIT_W-1:0], qdigit};
            rem_next   = rem_step;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = shift_reg;

endmodule

[sv/ccu_core.sv]
// ccu_core: request decode and step sequencer; each step multiplies the
// running count by a factor and divides exactly via ccu_divider. Depends on ccu_pkg and ccu_if.
module ccu_core
(
    input  logic              clk,
    input  logic              rst_n,
    ccu_req_if.sink           req,
    ccu_rsp_if.source         res,
    output ccu_pkg::div_cmd_t div_cmd,
    input  ccu_pkg::div_rsp_t div_rsp
);
    import ccu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_WAIT, S_DONE} state_t;

    state_t            state_reg,  state_next;
    logic [VAL_W-1:0]  acc_reg,    acc_next;
    logic [STAT_W-1:0] stat_reg,   stat_next;
    logic [N_W-1:0]    i_reg,      i_next;
    logic [N_W-1:0]    steps_reg,  steps_next;
    logic [F_W-1:0]    fadd_reg,   fadd_next;
    logic              inc_reg,    inc_next;
    logic              binom_reg,  binom_next;

    logic [N_W-1:0] n_in;
    logic [N_W-1:0] m_in;
    logic [N_W-1:0] n_minus_m;
    logic [N_W-1:0] k_sel;
    logic           bad;
    logic [N_W-1:0] steps_set;
    logic [F_W-1:0] fadd_set;
    logic           inc_set;
    logic           binom_set;
    logic [F_W-1:0] factor;

    assign n_in      = req.set_size;
    assign m_in      = req.subset_size;
    assign n_minus_m = n_in - m_in;
    assign k_sel     = (m_in > n_minus_m) ? n_minus_m : m_in;

    // operand checks and step plan per mode
    always_comb
    begin
        bad       = (n_in > N_W'(MAX_N));
        steps_set = m_in;
        fadd_set  = '0;
        inc_set   = 1'b1;
        binom_set = 1'b0;
        if (req.req_type != MODE_FACT && (n_in == '0 || m_in == '0 || m_in > n_in))
            bad = 1'b1;
        case (req.req_type)
            MODE_POWER:
            begin
                fadd_set = F_W'(n_in);
                inc_set  = 1'b0;
            end
            MODE_FALLING:
            begin
                fadd_set = F_W'(n_minus_m);
            end
            MODE_MULTISET:
            begin
                fadd_set  = F_W'(n_in - 1'b1);
                binom_set = 1'b1;
            end
            MODE_CHOOSE:
            begin
                steps_set = k_sel;
                fadd_set  = F_W'(n_in - k_sel);
                binom_set = 1'b1;
            end
            MODE_FACT:
            begin
                steps_set = n_in;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    assign factor = fadd_reg + (inc_reg ? F_W'(i_reg) : F_W'(0));

    assign div_cmd.start    = (state_reg == S_MUL);
    assign div_cmd.dividend = PROD_W'(acc_reg) * PROD_W'(factor);
    assign div_cmd.divisor  = binom_reg ? i_reg : N_W'(1);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        stat_next  = stat_reg;
        i_next     = i_reg;
        steps_next = steps_reg;
        fadd_next  = fadd_reg;
        inc_next   = inc_reg;
        binom_next = binom_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    i_next     = N_W'(1);
                    steps_next = steps_set;
                    fadd_next  = fadd_set;
                    inc_next   = inc_set;
                    binom_next = binom_set;
                    if (bad)
                    begin
                        acc_next   = '0;
                        stat_next  = STAT_BAD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = VAL_W'(1);
                        stat_next  = STAT_OK;
                        state_next = (steps_set == '0) ? S_DONE : S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[PROD_W-1:VAL_W] != '0)
                    begin
                        acc_next   = '1;
                        stat_next  = STAT_OVF;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next = div_rsp.quotient[VAL_W-1:0];
                        i_next   = i_reg + 1'b1;
                        state_next = (i_reg == steps_reg) ? S_DONE : S_MUL;
                    end
                end
            end
            S_DONE:
            begin
                if (res.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            stat_reg  <= STAT_OK;
            i_reg     <= '0;
            steps_reg <= '0;
            fadd_reg  <= '0;
            inc_reg   <= 1'b0;
            binom_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            stat_reg  <= stat_next;
            i_reg     <= i_next;
            steps_reg <= steps_next;
            fadd_reg  <= fadd_next;
            inc_reg   <= inc_next;
            binom_reg <= binom_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_DONE);
    assign res.count_value = acc_reg;
    assign res.status      = stat_reg;

endmodule

[sv/combinatorial_count_unit.sv]
// combinatorial_count_unit: top level with core, divider and output register.
// Depends on ccu_pkg, ccu_if, ccu_divider and ccu_core.
//
// usage
//   req channel: one word of req_type, set_size (n), subset_size (m)
//   rsp channel: one word of count_value (64 bits) and status per request
//   modes: 0 n^m, 1 n!/(n-m)!, 2 C(n+m-1,m), 3 C(n,m), 4 n!
//   status 0 ok, 1 overflow (value all ones), 2 bad operands (value 0)
// timing
//   the core handles one request at a time and drops req.ready meanwhile
//   bad operands: the core goes straight from idle to done, with no steps
//   otherwise the core runs s steps, s = m (modes 0..2), min(m,n-m) (mode 3), n (mode 4),
//   fewer when overflow ends the run early
//   each step is one 64x8 multiply plus a division of the product by the 8-bit-per-cycle divider
// reset and stalls
//   rst_n clears the sequencer, divider and output register; no clearing pass
//   a finished word waits in the output register while rsp.ready is low, and
//   the core may take the next request; it holds its own result until the
//   output register frees up
module combinatorial_count_unit
(
    input  logic      clk,
    input  logic      rst_n,
    ccu_req_if.sink   req,
    ccu_rsp_if.source rsp
);
    import ccu_pkg::*;

    ccu_rsp_if core_rsp ();

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic [STAT_W-1:0] out_stat_reg,  out_stat_next;

    ccu_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (core_rsp.source),
        .div_cmd (div_cmd),
        .div_rsp (div_rsp)
    );

    ccu_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    assign core_rsp.ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_stat_next  = out_stat_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (core_rsp.valid && core_rsp.ready)
        begin
            out_valid_next = 1'b1;
            out_value_next = core_rsp.count_value;
            out_stat_next  = core_rsp.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_stat_reg  <= out_stat_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.count_value = out_value_reg;
    assign rsp.status      = out_stat_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("core accepted a word while busy");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_OVF) |-> (rsp.count_value == '1))
        else $error("overflow word not saturated");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_BAD) |-> (rsp.count_value == '0))
        else $error("invalid word has nonzero value");

    a_div_not_during_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> !req.ready)
        else $error("divider finished while core idle");

endmodule
